// ===== rtl/sync_length_checksum_deframer_defines.svh =====
// ----------------------------------------------------------------------------
// Sync/length/checksum deframer assertion macros
// Shared assertion shorthands, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SYNC_LENGTH_CHECKSUM_DEFRAMER_DEFINES_SVH
`define SYNC_LENGTH_CHECKSUM_DEFRAMER_DEFINES_SVH

// same-cycle implication
`define SLCD_ASSERT_IMPL(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("slcd assertion failed");

// next-cycle implication
`define SLCD_ASSERT_NEXT(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("slcd assertion failed");

`endif

// ===== rtl/slcd_pkg.sv =====
// ----------------------------------------------------------------------------
// Sync/length/checksum deframer package
// Shared types, codes and constants of the deframer.
// ----------------------------------------------------------------------------
package slcd_pkg;

   localparam int ByteWidth    = 8;
   localparam int LengthWidth  = 16;
   localparam int CsrIndexWidth = 1;
   localparam int RspDataWidth = 24;   // out_byte, frame_marker, frame_status, pad

   localparam logic [ByteWidth-1:0] SyncFirstReset  = 8'h55;
   localparam logic [ByteWidth-1:0] SyncSecondReset = 8'hAA;

   // register indexes
   localparam logic [CsrIndexWidth-1:0] CSR_SYNC_FIRST  = 1'b0;
   localparam logic [CsrIndexWidth-1:0] CSR_SYNC_SECOND = 1'b1;

   // input kinds
   localparam logic KIND_BYTE    = 1'b0;
   localparam logic KIND_RESTART = 1'b1;

   typedef enum logic [1:0] {
      ROLE_MARKER    = 2'd0,
      ROLE_PAYLOAD   = 2'd1,
      ROLE_FRAME_END = 2'd2
   } role_type;

   typedef enum logic [7:0] {
      PH_HUNT1   = 8'b0000_0001,
      PH_HUNT2   = 8'b0000_0010,
      PH_LEN_LO  = 8'b0000_0100,
      PH_LEN_HI  = 8'b0000_1000,
      PH_MARKER  = 8'b0001_0000,
      PH_PAYLOAD = 8'b0010_0000,
      PH_CHECK   = 8'b0100_0000,
      PH_DONE    = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      logic [ByteWidth-1:0] sync_first;
      logic [ByteWidth-1:0] sync_second;
   } sync_cfg_type;

   typedef struct packed {
      logic [ByteWidth-1:0] out_byte;
      role_type             byte_role;
      logic [ByteWidth-1:0] frame_marker;
      logic                 frame_status;
      logic                 is_last;
   } rsp_item_type;

endpackage

// ===== rtl/slcd_csr.sv =====
// ----------------------------------------------------------------------------
// Deframer configuration registers
// Holds the two sync bytes; writes complete in the cycle they are offered.
// ----------------------------------------------------------------------------
module slcd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [slcd_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [slcd_pkg::ByteWidth-1:0]      csr_wdata,
   output slcd_pkg::sync_cfg_type              sync_cfg
);

   slcd_pkg::sync_cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign sync_cfg  = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            slcd_pkg::CSR_SYNC_FIRST:  cfg_in.sync_first  = csr_wdata;
            slcd_pkg::CSR_SYNC_SECOND: cfg_in.sync_second = csr_wdata;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_first  <= slcd_pkg::SyncFirstReset;
         cfg_ff.sync_second <= slcd_pkg::SyncSecondReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/slcd_parser.sv =====
// ----------------------------------------------------------------------------
// Deframer parse stage: input register plus the frame state machine.
// One byte is parsed per cycle unless the result register stalls it.
// ----------------------------------------------------------------------------
module slcd_parser (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic                            req_kind,
   input  logic [slcd_pkg::ByteWidth-1:0]  req_byte,
   input  slcd_pkg::sync_cfg_type          sync_cfg,
   input  logic                            out_take,
   output logic                            item_valid,
   output slcd_pkg::rsp_item_type          item,
   output logic                            parse_fire
);

   logic                              in_valid_ff, in_valid_in;
   logic                              in_kind_ff;
   logic [slcd_pkg::ByteWidth-1:0]    in_byte_ff;

   slcd_pkg::phase_type               phase_ff, phase_in;
   logic [slcd_pkg::LengthWidth-1:0]  length_ff, length_in;
   logic [slcd_pkg::LengthWidth-1:0]  seen_ff, seen_in;
   logic [slcd_pkg::LengthWidth-1:0]  seen_next;
   logic [slcd_pkg::ByteWidth-1:0]    marker_ff, marker_in;
   logic [slcd_pkg::ByteWidth-1:0]    sum_ff, sum_in;
   logic                              produce;
   logic                              req_fire;

   assign seen_next = seen_ff + 16'd1;

   always_comb begin
      phase_in  = phase_ff;
      length_in = length_ff;
      seen_in   = seen_ff;
      marker_in = marker_ff;
      sum_in    = sum_ff;
      produce   = 1'b0;
      item.out_byte     = in_byte_ff;
      item.byte_role    = slcd_pkg::ROLE_MARKER;
      item.frame_marker = marker_ff;
      item.frame_status = 1'b0;
      item.is_last      = 1'b0;

      if (in_kind_ff == slcd_pkg::KIND_RESTART) begin
         phase_in  = slcd_pkg::PH_HUNT1;
         length_in = '0;
         seen_in   = '0;
         marker_in = '0;
         sum_in    = '0;
      end else begin
         unique case (phase_ff)
            slcd_pkg::PH_HUNT1: begin
               if (in_byte_ff == sync_cfg.sync_first) phase_in = slcd_pkg::PH_HUNT2;
            end
            slcd_pkg::PH_HUNT2: begin
               // second sync wins when both registers hold the same byte
               if (in_byte_ff == sync_cfg.sync_second) begin
                  phase_in = slcd_pkg::PH_LEN_LO;
               end else if (in_byte_ff != sync_cfg.sync_first) begin
                  phase_in = slcd_pkg::PH_HUNT1;
               end
            end
            slcd_pkg::PH_LEN_LO: begin
               length_in = {8'h00, in_byte_ff};
               phase_in  = slcd_pkg::PH_LEN_HI;
            end
            slcd_pkg::PH_LEN_HI: begin
               length_in = {in_byte_ff, length_ff[7:0]};
               phase_in  = slcd_pkg::PH_MARKER;
            end
            slcd_pkg::PH_MARKER: begin
               marker_in = in_byte_ff;
               sum_in    = in_byte_ff;
               seen_in   = 16'd1;
               // length of zero or one: checksum follows the marker
               phase_in  = (length_ff <= 16'd1) ? slcd_pkg::PH_CHECK : slcd_pkg::PH_PAYLOAD;
               produce   = 1'b1;
               item.frame_marker = in_byte_ff;
            end
            slcd_pkg::PH_PAYLOAD: begin
               sum_in  = sum_ff + in_byte_ff;
               seen_in = seen_next;
               if (seen_next >= length_ff) phase_in = slcd_pkg::PH_CHECK;
               produce = 1'b1;
               item.byte_role = slcd_pkg::ROLE_PAYLOAD;
            end
            slcd_pkg::PH_CHECK: begin
               phase_in = slcd_pkg::PH_DONE;
               produce  = 1'b1;
               item.byte_role    = slcd_pkg::ROLE_FRAME_END;
               item.frame_status = (sum_ff != in_byte_ff);
               item.is_last      = 1'b1;
            end
            slcd_pkg::PH_DONE: begin
               phase_in = slcd_pkg::PH_DONE;
            end
            default: begin
               phase_in = slcd_pkg::PH_HUNT1;
            end
         endcase
      end
   end

   // a byte that yields nothing moves on even when the result register is full
   assign parse_fire  = in_valid_ff && (!produce || out_take);
   assign item_valid  = in_valid_ff && produce;
   assign req_tready  = !in_valid_ff || parse_fire;
   assign req_fire    = req_tvalid && req_tready;
   assign in_valid_in = req_fire || (in_valid_ff && !parse_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_kind_ff <= req_kind;
         in_byte_ff <= req_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= slcd_pkg::PH_HUNT1;
         length_ff <= '0;
         seen_ff   <= '0;
         marker_ff <= '0;
         sum_ff    <= '0;
      end else if (parse_fire) begin
         phase_ff  <= phase_in;
         length_ff <= length_in;
         seen_ff   <= seen_in;
         marker_ff <= marker_in;
         sum_ff    <= sum_in;
      end
   end

endmodule

// ===== rtl/slcd_rsp_reg.sv =====
// ----------------------------------------------------------------------------
// Deframer result register
// Holds one result transaction until the downstream side takes it.
// ----------------------------------------------------------------------------
module slcd_rsp_reg (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                item_valid,
   input  slcd_pkg::rsp_item_type              item,
   output logic                                out_take,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [slcd_pkg::RspDataWidth-1:0]   rsp_tdata,
   output logic [1:0]                          rsp_tuser,
   output logic                                rsp_tlast
);

   logic                    valid_ff, valid_in;
   slcd_pkg::rsp_item_type  item_ff;

   assign out_take = !valid_ff || rsp_tready;
   assign valid_in = item_valid || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_valid && out_take) begin
         item_ff <= item;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {7'd0, item_ff.frame_status, item_ff.frame_marker, item_ff.out_byte};
   assign rsp_tuser  = item_ff.byte_role;
   assign rsp_tlast  = item_ff.is_last;

endmodule

// ===== rtl/sync_length_checksum_deframer.sv =====
// ----------------------------------------------------------------------------
// Sync/length/checksum deframer
// Finds frames behind two sync bytes and streams out marker, payload and a
// checked frame end.
// ----------------------------------------------------------------------------
// One byte is taken per cycle unless req_tready is low. A byte waits in the input
// register, where the frame state machine parses it, and its result (if any) is
// captured in the result register, which drives rsp_tvalid. Throughput is one
// byte per clock; req_tready drops only while the result register holds an
// untaken result and the byte waiting to be parsed would produce another. Header
// bytes, sync hunting and bytes after a frame end produce no result. A restart
// item (tuser = 1) returns the parser to the sync hunt. Configuration writes take
// effect at once and should be made while no bytes are in flight.
`include "sync_length_checksum_deframer_defines.svh"

module sync_length_checksum_deframer (
   input  logic                                clock,
   input  logic                                reset,
   // input stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,  // [7:0] data_byte
   input  logic                                req_tuser,  // [0] kind
   // result stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [7:0] out_byte, [15:8] frame_marker, [16] frame_status, [23:17] zero
   output logic [slcd_pkg::RspDataWidth-1:0]   rsp_tdata,
   output logic [1:0]                          rsp_tuser,  // [1:0] byte_role
   output logic                                rsp_tlast,  // is_last
   // configuration writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [slcd_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [slcd_pkg::ByteWidth-1:0]      csr_wdata
);

   slcd_pkg::sync_cfg_type  sync_cfg;
   slcd_pkg::rsp_item_type  item;
   logic                    item_valid;
   logic                    out_take;
   logic                    parse_fire;

   slcd_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .sync_cfg   (sync_cfg)
   );

   slcd_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .req_byte   (req_tdata),
      .sync_cfg   (sync_cfg),
      .out_take   (out_take),
      .item_valid (item_valid),
      .item       (item),
      .parse_fire (parse_fire)
   );

   slcd_rsp_reg u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .out_take   (out_take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // input backpressure comes only from a stalled result register
   `SLCD_ASSERT_IMPL(a_stall_source, !req_tready, rsp_tvalid && !rsp_tready)
   // no result shows up unless a byte was parsed
   `SLCD_ASSERT_NEXT(a_no_phantom, !parse_fire && !(rsp_tvalid && !rsp_tready), !rsp_tvalid)
   // tlast marks exactly the frame-end results
   `SLCD_ASSERT_IMPL(a_last_role, rsp_tvalid,
      rsp_tlast == (rsp_tuser == slcd_pkg::ROLE_FRAME_END))

endmodule
